// ===== rtl/uttc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Unix time to calendar converter.
// Holds the division reciprocals, calendar constants and the month start table.
// No dependencies.
package uttc_pkg;

  // Register stages in the converter pipeline.
  localparam int unsigned STAGES = 6;

  // Seconds to days: ts / 86400 = (ts >> 7) / 675, done as a reciprocal multiply.
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_SHIFT = 35;
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // Day numbers of 2000-01-01 and 2100-01-01 counted from 1970-01-01.
  localparam logic [15:0] DAY_2000 = 16'd10957;
  localparam logic [15:0] DAY_2100 = 16'd47482;

  // Four-year blocks inside 2000..2099.
  localparam int unsigned QUAD_SHIFT = 26;
  localparam logic [15:0] QUAD_RECIP = 16'd45934;
  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
  localparam logic [10:0] QUAD_YEAR1 = 11'd366;
  localparam logic [10:0] QUAD_YEAR2 = 11'd731;
  localparam logic [10:0] QUAD_YEAR3 = 11'd1096;

  // Weekday: 1970-01-01 was a Thursday.
  localparam int unsigned WEEK_SHIFT = 19;
  localparam logic [16:0] WEEK_RECIP = 17'd74899;
  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
  localparam logic [15:0] WEEK_OFFSET = 16'd3;

  // Seconds of day to hours: (sod >> 4) / 225.
  localparam int unsigned HOUR_PRE_SHIFT = 4;
  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // Seconds of hour to minutes: (rem >> 2) / 15.
  localparam int unsigned MIN_PRE_SHIFT = 2;
  localparam int unsigned MIN_SHIFT = 14;
  localparam logic [10:0] MIN_RECIP = 11'd1093;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;

  localparam int unsigned MONTHS = 12;

  typedef struct packed {
    logic [8:0] doy;   // zero-based day of year
    logic       leap;
  } doy_t;

  // Zero-based day of year on which a month (zero-based index) starts.
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && idx >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== rtl/uttc_month.sv =====
`timescale 1ns / 1ps
// Day of year to month and day of month, January based.
// Depends on uttc_pkg for the month start table.
module uttc_month (
  input  uttc_pkg::doy_t doy_in,
  output logic [3:0]     month,
  output logic [4:0]     day_of_month
);
  import uttc_pkg::*;

  logic [3:0] idx;
  logic [8:0] start;
  logic [8:0] offset;

  // Count the month starts at or below the day; the eleven compares run in parallel.
  always_comb begin
    idx = 4'd0;
    for (int i = 1; i < MONTHS; i++) begin
      idx = idx + 4'(doy_in.doy >= month_start(4'(i), doy_in.leap));
    end
  end

  assign start = month_start(idx, doy_in.leap);
  assign offset = doy_in.doy - start + 9'd1;
  assign month = idx + 4'd1;
  assign day_of_month = offset[4:0];

endmodule

// ===== rtl/unix_time_to_calendar.sv =====
`timescale 1ns / 1ps
// Six-stage converter from a 32-bit Unix timestamp to a 2000..2099 calendar date and time.
// Depends on uttc_pkg and uttc_month.
//
// Each beat on the input carries one timestamp and yields exactly one result beat. The
// pipeline takes a new timestamp every cycle unless a stalled output has backed it up; it
// has six register stages, each holding about one reciprocal multiply and one subtract,
// and each stage holds its item only while the stage after it is full and stalled, so
// bubbles close up. Years outside 2000..2099 give status 1 with every other field zero.
// Weekday is 1 for Monday through 7 for Sunday.
module unix_time_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] unix_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  year_offset,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds,
  output logic [2:0]  weekday,
  output logic        status
);
  import uttc_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: whole days.
  logic [24:0] ts_pre;
  logic [50:0] day_prod;
  logic [31:0] s1_ts;
  logic [15:0] s1_days;

  assign ts_pre = unix_seconds[31:DAY_PRE_SHIFT];
  assign day_prod = 51'(ts_pre) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_ts <= unix_seconds;
      s1_days <= day_prod[DAY_SHIFT+15:DAY_SHIFT];
    end
  end

  // Stage 2: seconds of day, range check, offsets for the date and weekday.
  logic [32:0] sod_prod;
  logic [31:0] sod_full;
  logic [16:0] s2_sod;
  logic [15:0] s2_d;
  logic [15:0] s2_x7;
  logic        s2_status;

  assign sod_prod = 33'(s1_days) * 33'(SECS_PER_DAY);
  assign sod_full = s1_ts - sod_prod[31:0];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_sod <= sod_full[16:0];
      s2_d <= s1_days - DAY_2000;
      s2_x7 <= s1_days + WEEK_OFFSET;
      s2_status <= (s1_days < DAY_2000) || (s1_days >= DAY_2100);
    end
  end

  // Stage 3: quotients by 1461, 7 and 3600.
  logic [31:0] quad_prod;
  logic [32:0] week_prod;
  logic [12:0] sod_pre;
  logic [25:0] hour_prod;
  logic [15:0] s3_d;
  logic [5:0]  s3_q4;
  logic [15:0] s3_x7;
  logic [13:0] s3_qw;
  logic [16:0] s3_sod;
  logic [4:0]  s3_hours;
  logic        s3_status;

  assign quad_prod = 32'(s2_d) * 32'(QUAD_RECIP);
  assign week_prod = 33'(s2_x7) * 33'(WEEK_RECIP);
  assign sod_pre = s2_sod[16:HOUR_PRE_SHIFT];
  assign hour_prod = 26'(sod_pre) * 26'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_d <= s2_d;
      s3_q4 <= quad_prod[QUAD_SHIFT+5:QUAD_SHIFT];
      s3_x7 <= s2_x7;
      s3_qw <= week_prod[WEEK_SHIFT+13:WEEK_SHIFT];
      s3_sod <= s2_sod;
      s3_hours <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
      s3_status <= s2_status;
    end
  end

  // Stage 4: remainders.
  logic [16:0] quad_back;
  logic [15:0] quad_rem;
  logic [16:0] week_back;
  logic [15:0] week_rem;
  logic [16:0] hour_back;
  logic [16:0] hour_rem;
  logic [10:0] s4_r;
  logic [4:0]  s4_q4;
  logic [2:0]  s4_wd;
  logic [4:0]  s4_hours;
  logic [11:0] s4_hrem;
  logic        s4_status;

  assign quad_back = 17'(s3_q4) * 17'(DAYS_PER_QUAD);
  assign quad_rem = s3_d - quad_back[15:0];
  assign week_back = 17'(s3_qw) * 17'(DAYS_PER_WEEK);
  assign week_rem = s3_x7 - week_back[15:0];
  assign hour_back = 17'(s3_hours) * 17'(SECS_PER_HOUR);
  assign hour_rem = s3_sod - hour_back;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_r <= quad_rem[10:0];
      s4_q4 <= s3_q4[4:0];
      s4_wd <= week_rem[2:0];
      s4_hours <= s3_hours;
      s4_hrem <= hour_rem[11:0];
      s4_status <= s3_status;
    end
  end

  // Stage 5: year within the four-year block (the first one is the leap year), minutes.
  logic [1:0]  yib;
  logic [10:0] year_start;
  logic [10:0] doy_full;
  logic [9:0]  hrem_pre;
  logic [19:0] min_prod;
  logic [6:0]  s5_year;
  doy_t        s5_doy;
  logic [2:0]  s5_wd;
  logic [4:0]  s5_hours;
  logic [11:0] s5_hrem;
  logic [5:0]  s5_minutes;
  logic        s5_status;

  always_comb begin
    priority if (s4_r < QUAD_YEAR1) begin
      yib = 2'd0;
      year_start = 11'd0;
    end else if (s4_r < QUAD_YEAR2) begin
      yib = 2'd1;
      year_start = QUAD_YEAR1;
    end else if (s4_r < QUAD_YEAR3) begin
      yib = 2'd2;
      year_start = QUAD_YEAR2;
    end else begin
      yib = 2'd3;
      year_start = QUAD_YEAR3;
    end
  end

  assign doy_full = s4_r - year_start;
  assign hrem_pre = s4_hrem[11:MIN_PRE_SHIFT];
  assign min_prod = 20'(hrem_pre) * 20'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_year <= {s4_q4, yib};
      s5_doy.doy <= doy_full[8:0];
      s5_doy.leap <= (yib == 2'd0);
      s5_wd <= s4_wd;
      s5_hours <= s4_hours;
      s5_hrem <= s4_hrem;
      s5_minutes <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
      s5_status <= s4_status;
    end
  end

  // Stage 6: month, day and seconds into the output register.
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [11:0] min_back;
  logic [11:0] sec_rem;

  uttc_month u_month (
    .doy_in       (s5_doy),
    .month        (cal_month),
    .day_of_month (cal_day)
  );

  assign min_back = 12'(s5_minutes) * 12'(SECS_PER_MIN);
  assign sec_rem = s5_hrem - min_back;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      status <= s5_status;
      if (s5_status) begin
        year_offset <= '0;
        month <= '0;
        day_of_month <= '0;
        hours <= '0;
        minutes <= '0;
        seconds <= '0;
        weekday <= '0;
      end else begin
        year_offset <= s5_year;
        month <= cal_month;
        day_of_month <= cal_day;
        hours <= s5_hours;
        minutes <= s5_minutes;
        seconds <= sec_rem[5:0];
        weekday <= s5_wd + 3'd1;
      end
    end
  end

  // An empty output register lets the whole ready chain open.
  a_empty_out_ready : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_date_range : assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> month >= 4'd1 && month <= 4'd12 &&
      day_of_month >= 5'd1 && year_offset <= 7'd99)
    else $error("calendar date out of range");

  a_time_range : assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> hours <= 5'd23 && minutes <= 6'd59 && seconds <= 6'd59)
    else $error("time of day out of range");

  a_weekday : assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> weekday != 3'd0)
    else $error("weekday zero on an in-range result");

  a_status_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> month == 4'd0 && weekday == 3'd0 && day_of_month == 5'd0)
    else $error("out-of-range result carries a date");

endmodule

// ===== verif/tb_unix_time_to_calendar.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for unix_time_to_calendar: directed and random timestamps,
// with a behavioral calendar predictor and random stalls on both handshakes.
// Depends only on the converter RTL and its package.
module tb_unix_time_to_calendar;

  typedef struct {
    int unsigned year_offset;
    int unsigned month;
    int unsigned day_of_month;
    int unsigned hours;
    int unsigned minutes;
    int unsigned seconds;
    int unsigned weekday;
    int unsigned status;
  } calendar_t;

  localparam int unsigned STAMP_2000 = 32'd946684800;
  localparam int unsigned STAMP_2100 = 32'd4102444800;
  localparam int unsigned NUM_RANDOM = 1000;
  localparam int unsigned IDLE_PERCENT = 17;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] unix_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  year_offset;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [2:0]  weekday;
  logic        status;

  logic [31:0] pending_stamps[$];
  calendar_t   expected_dates[$];
  int unsigned total_stamps = 0;
  int unsigned sent_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  logic        stamp_taken = 1'b0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        no_idle;

  unix_time_to_calendar i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .unix_seconds (unix_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year_offset  (year_offset),
    .month        (month),
    .day_of_month (day_of_month),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .weekday      (weekday),
    .status       (status)
  );

  always #5 clk = ~clk;

  // A window in the middle of the run where neither side idles.
  assign no_idle = (sent_count >= 400) && (sent_count < 600);

  // Civil date from a day count, with the era split anchored at 0000-03-01.
  function automatic calendar_t to_calendar(input logic [31:0] stamp);
    calendar_t   cal;
    int unsigned sec_of_day, day_num, shifted, era_idx, day_of_era, year_of_era;
    int unsigned day_of_year, mar_month, dom, mon, yr, zy, zm, h;
    sec_of_day = stamp % 86400;
    day_num = stamp / 86400;
    shifted = day_num + 719468;
    era_idx = shifted / 146097;
    day_of_era = shifted - era_idx * 146097;
    year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                   - day_of_era / 146096) / 365;
    day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
    mar_month = (5 * day_of_year + 2) / 153;
    dom = day_of_year - (153 * mar_month + 2) / 5 + 1;
    mon = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
    yr = year_of_era + era_idx * 400;
    if (mon <= 2) begin
      yr = yr + 1;
    end
    cal = '{default: 0};
    if (yr < 2000 || yr > 2099) begin
      cal.status = 1;
      return cal;
    end
    // Zeller: January and February count as months 13 and 14 of the year before.
    zy = yr;
    zm = mon;
    if (zm < 3) begin
      zm = zm + 12;
      zy = zy - 1;
    end
    h = (dom + (13 * (zm + 1)) / 5 + zy + zy / 4 - zy / 100 + zy / 400) % 7;
    cal.year_offset = yr - 2000;
    cal.month = mon;
    cal.day_of_month = dom;
    cal.hours = sec_of_day / 3600;
    cal.minutes = (sec_of_day % 3600) / 60;
    cal.seconds = sec_of_day % 60;
    cal.weekday = (h + 5) % 7 + 1;
    return cal;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Input driver: a new beat is offered only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || stamp_taken)) begin
      if (pending_stamps.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
        in_valid <= 1'b1;
        unix_seconds <= pending_stamps.pop_front();
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stalls plus one long hold-off that backs up the pipeline.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && sent_count >= 200) begin
        out_ready <= 1'b0;
        hold_left <= 60;
        hold_done <= 1'b1;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Input monitor: each accepted beat queues its predicted calendar result.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_dates.push_back(to_calendar(unix_seconds));
      accepted_count <= accepted_count + 1;
      stamp_taken <= 1'b1;
    end else begin
      stamp_taken <= 1'b0;
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    calendar_t exp_cal;
    if (!rst && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result beat with no timestamp outstanding");
        error_count++;
      end else begin
        exp_cal = expected_dates.pop_front();
        check_field("year_offset", exp_cal.year_offset, year_offset);
        check_field("month", exp_cal.month, month);
        check_field("day_of_month", exp_cal.day_of_month, day_of_month);
        check_field("hours", exp_cal.hours, hours);
        check_field("minutes", exp_cal.minutes, minutes);
        check_field("seconds", exp_cal.seconds, seconds);
        check_field("weekday", exp_cal.weekday, weekday);
        check_field("status", exp_cal.status, status);
      end
    end
  end

  initial begin
    int unsigned pick, day_idx;
    logic [31:0] directed[$];
    // Range edges, leap days, year and day ends, and the 2^31 crossing.
    directed = '{32'd0, 32'hFFFF_FFFF, STAMP_2000 - 1, STAMP_2000, 32'd951782400,
                 32'd951868799, 32'd951868800, 32'd978307199, 32'd978307200,
                 STAMP_2100 - 1, STAMP_2100, 32'd1709164800, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'd4107542399};
    // One timestamp on each weekday, starting from a Saturday.
    for (int k = 0; k < 7; k++) begin
      directed.push_back(STAMP_2000 + k * 86400 + k * 12345);
    end
    foreach (directed[i]) begin
      pending_stamps.push_back(directed[i]);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        pending_stamps.push_back($urandom_range(STAMP_2100 - 1, STAMP_2000));
      end else if (pick < 88) begin
        pending_stamps.push_back($urandom);
      end else begin
        // First or last second of a random day inside the valid century.
        day_idx = $urandom_range(36524);
        pending_stamps.push_back(STAMP_2000 + day_idx * 86400
                                 + (($urandom_range(1) == 1) ? 86399 : 0));
      end
    end
    total_stamps = pending_stamps.size();

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    while (accepted_count < total_stamps) @(posedge clk);
    while (expected_dates.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_unix_time_to_calendar: done, clean");
    end else begin
      $display("tb_unix_time_to_calendar: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_unix_time_to_calendar: done, errors");
    $finish;
  end

endmodule
